### sv/kdk_pkg.sv
package kdk_pkg;

   localparam int N_PHOTONS = 1024;
   localparam int K_MAX = 16;
   localparam int COORD_BITS = 16;

   localparam int SLOT_W = $clog2(N_PHOTONS);
   localparam int CNT_W = $clog2(N_PHOTONS + 1);
   localparam int DIST_W = 2 * COORD_BITS + 2;
   localparam int SQ_W = 2 * COORD_BITS;
   localparam int LIM_W = $clog2(K_MAX + 1);
   localparam int HIDX_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int STACK_DEPTH = SLOT_W + 1;
   localparam int SIDX_W = $clog2(STACK_DEPTH);
   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] AXIS_LEAF = 2'd0;
   localparam logic [1:0] AXIS_X = 2'd1;
   localparam logic [1:0] AXIS_Y = 2'd2;
   localparam logic [1:0] AXIS_Z = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SQ_DIST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBOR_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHOTON_COUNT = 2'd2;

   localparam logic [DIST_W-1:0] MAX_SQ_DIST_RESET = DIST_W'(64'd12884508675);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic signed [COORD_BITS-1:0] dir_x;
      logic signed [COORD_BITS-1:0] dir_y;
      logic signed [COORD_BITS-1:0] dir_z;
      logic [1:0] axis;
   } photon_type;

   localparam int PHOTON_W = $bits(photon_type);

   typedef struct packed {
      logic [CNT_W-1:0] lo;
      logic [CNT_W-1:0] hi;
      logic near_high;
   } frame_type;

   typedef struct packed {
      logic shift;
      logic we;
   } cell_ctl_type;

endpackage

### sv/kdk_ram.sv
module kdk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/kdk_cell.sv
module kdk_cell (
   input  logic clock,
   input  kdk_pkg::cell_ctl_type ctl,
   input  logic [kdk_pkg::SLOT_W-1:0] nb_slot,
   input  logic [kdk_pkg::DIST_W-1:0] nb_dist,
   input  logic [kdk_pkg::SLOT_W-1:0] wr_slot,
   input  logic [kdk_pkg::DIST_W-1:0] wr_dist,
   output logic [kdk_pkg::SLOT_W-1:0] slot,
   output logic [kdk_pkg::DIST_W-1:0] dist_out
);

   logic [kdk_pkg::SLOT_W-1:0] slot_ff;
   logic [kdk_pkg::DIST_W-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         slot_ff <= wr_slot;
         dist_ff <= wr_dist;
      end else if (ctl.shift) begin
         slot_ff <= nb_slot;
         dist_ff <= nb_dist;
      end
   end

   assign slot = slot_ff;
   assign dist_out = dist_ff;

endmodule

### sv/kd_tree_k_nearest_search.sv
// Load requests are written straight into the photon store, produce no result and leave busy low.
// A query walks the tree over leaves, inner nodes and empty subranges, and moves each heap
// insertion or removal through the heap one level at a time.
// After the walk, one result per cycle follows: one per kept neighbour, or a single empty one.
// One request at a time; results cannot be stalled.
// Reset is synchronous and sets control and configuration to their defaults; the photon store is not cleared.
module kd_tree_k_nearest_search (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_op,
   input  logic [kdk_pkg::SLOT_W-1:0] req_slot,
   input  logic signed [kdk_pkg::COORD_BITS-1:0] req_coord_x,
   input  logic signed [kdk_pkg::COORD_BITS-1:0] req_coord_y,
   input  logic signed [kdk_pkg::COORD_BITS-1:0] req_coord_z,
   input  logic signed [kdk_pkg::COORD_BITS-1:0] req_vec_x,
   input  logic signed [kdk_pkg::COORD_BITS-1:0] req_vec_y,
   input  logic signed [kdk_pkg::COORD_BITS-1:0] req_vec_z,
   input  logic [1:0] req_split_axis,
   output logic rsp_strobe,
   output logic [kdk_pkg::SLOT_W-1:0] rsp_neighbor_slot,
   output logic [kdk_pkg::DIST_W-1:0] rsp_neighbor_sq_dist,
   output logic rsp_valid_res,
   output logic [kdk_pkg::LIM_W-1:0] rsp_neighbor_count,
   output logic [kdk_pkg::DIST_W-1:0] rsp_worst_sq_dist,
   output logic rsp_last,
   input  logic csr_write_enable,
   input  logic [kdk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kdk_pkg::DIST_W-1:0] csr_data
);

   localparam int CW = kdk_pkg::COORD_BITS;
   localparam int SW = kdk_pkg::SLOT_W;
   localparam int NW = kdk_pkg::CNT_W;
   localparam int DW = kdk_pkg::DIST_W;
   localparam int QW = kdk_pkg::SQ_W;
   localparam int LW = kdk_pkg::LIM_W;
   localparam int HW = kdk_pkg::HIDX_W;
   localparam int KM = kdk_pkg::K_MAX;
   localparam int SIDX_W_FIX = kdk_pkg::SIDX_W;

   typedef enum logic [3:0] {
      S_IDLE, S_WALK, S_NODE, S_RET, S_CONS_MUL, S_CONS_SUM, S_SD, S_SU, S_AFTER, S_OUT
   } state_type;

   state_type state_ff;
   logic [DW-1:0] max_ff;
   logic [LW-1:0] limit_ff;
   logic [NW-1:0] count_ff;

   logic signed [CW-1:0] qx_ff, qy_ff, qz_ff, nx_ff, ny_ff, nz_ff;
   logic [LW-1:0] lim_ff;
   logic [NW-1:0] cur_lo_ff, cur_hi_ff;
   logic cur_nh_ff;
   kdk_pkg::frame_type stack_ff [kdk_pkg::STACK_DEPTH];
   logic [kdk_pkg::SP_W-1:0] sp_ff;
   logic cont_after_ff;
   logic [SW-1:0] cons_slot_ff;
   logic [QW-1:0] sq_x_ff, sq_y_ff, sq_z_ff, g2_ff;
   logic signed [QW-1:0] dp_x_ff, dp_y_ff, dp_z_ff;
   logic [LW-1:0] hs_ff;
   logic [DW-1:0] worst_ff;
   logic [SW-1:0] pend_slot_ff;
   logic [DW-1:0] pend_dist_ff;
   logic [HW-1:0] hi_ff;
   logic [LW-1:0] out_k_ff;

   logic rsp_strobe_ff, rsp_valid_ff, rsp_last_ff;
   logic [SW-1:0] rsp_slot_ff;
   logic [DW-1:0] rsp_dist_ff, rsp_worst_ff;
   logic [LW-1:0] rsp_count_ff;

   logic accept_req;
   logic ram_we;
   logic [SW-1:0] ram_raddr;
   logic [kdk_pkg::PHOTON_W-1:0] ram_rdata;
   kdk_pkg::photon_type wr_ph, ph;

   logic [NW-1:0] mid_c, pop_mid_c;
   logic [kdk_pkg::SP_W-1:0] sp_m1;
   kdk_pkg::frame_type top_c;

   logic signed [CW-1:0] ax_p, ax_s;
   logic signed [CW:0] dx_c, dy_c, dz_c, g_c;
   logic signed [QW+1:0] sqx_full, sqy_full, sqz_full, g2_full;
   logic signed [QW-1:0] dpx_c, dpy_c, dpz_c;
   logic [DW-1:0] dist_sum;
   logic signed [QW+1:0] dot_sum;
   logic full_c, take_c;

   logic [SW-1:0] cell_slot [KM];
   logic [DW-1:0] cell_dist [KM];
   logic [LW:0] l_c, r_c, hs_ext;
   logic [HW-1:0] l_idx, r_idx, big_idx, p_idx, last_idx;
   logic sd_stop, su_stop;

   logic wa_en, wb_en, shift_c;
   logic [HW-1:0] wa_idx, wb_idx;
   logic [SW-1:0] wa_slot, wb_slot;
   logic [DW-1:0] wa_dist, wb_dist;

   assign busy = (state_ff != S_IDLE);
   assign accept_req = start && !busy;
   assign ram_we = accept_req && (req_op == kdk_pkg::OP_LOAD);

   always_comb begin
      wr_ph.pos_x = req_coord_x;
      wr_ph.pos_y = req_coord_y;
      wr_ph.pos_z = req_coord_z;
      wr_ph.dir_x = req_vec_x;
      wr_ph.dir_y = req_vec_y;
      wr_ph.dir_z = req_vec_z;
      wr_ph.axis = req_split_axis;
   end

   kdk_ram #(
      .WIDTH(kdk_pkg::PHOTON_W),
      .DEPTH(kdk_pkg::N_PHOTONS)
   ) u_photon_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(req_slot),
      .wr_data(wr_ph),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign ph = kdk_pkg::photon_type'(ram_rdata);

   assign mid_c = cur_lo_ff + ((cur_hi_ff - cur_lo_ff) >> 1);
   assign sp_m1 = sp_ff - 1'b1;
   assign top_c = stack_ff[sp_m1[SIDX_W_FIX-1:0]];
   assign pop_mid_c = top_c.lo + ((top_c.hi - top_c.lo) >> 1);

   always_comb begin
      unique case (state_ff)
         S_WALK:  ram_raddr = (cur_hi_ff == cur_lo_ff + 1'b1) ? cur_lo_ff[SW-1:0]
                                                             : mid_c[SW-1:0];
         S_RET:   ram_raddr = pop_mid_c[SW-1:0];
         default: ram_raddr = mid_c[SW-1:0];
      endcase
   end

   always_comb begin
      unique case (ph.axis)
         kdk_pkg::AXIS_X: begin
            ax_p = qx_ff;
            ax_s = ph.pos_x;
         end
         kdk_pkg::AXIS_Y: begin
            ax_p = qy_ff;
            ax_s = ph.pos_y;
         end
         kdk_pkg::AXIS_Z: begin
            ax_p = qz_ff;
            ax_s = ph.pos_z;
         end
         default: begin
            ax_p = '0;
            ax_s = '0;
         end
      endcase
   end

   always_comb begin
      dx_c = {qx_ff[CW-1], qx_ff} - {ph.pos_x[CW-1], ph.pos_x};
      dy_c = {qy_ff[CW-1], qy_ff} - {ph.pos_y[CW-1], ph.pos_y};
      dz_c = {qz_ff[CW-1], qz_ff} - {ph.pos_z[CW-1], ph.pos_z};
      g_c = {ax_p[CW-1], ax_p} - {ax_s[CW-1], ax_s};
      sqx_full = dx_c * dx_c;
      sqy_full = dy_c * dy_c;
      sqz_full = dz_c * dz_c;
      g2_full = g_c * g_c;
      dpx_c = nx_ff * ph.dir_x;
      dpy_c = ny_ff * ph.dir_y;
      dpz_c = nz_ff * ph.dir_z;
   end

   always_comb begin
      dist_sum = DW'(sq_x_ff) + DW'(sq_y_ff) + DW'(sq_z_ff);
      dot_sum = (QW+2)'(dp_x_ff) + (QW+2)'(dp_y_ff) + (QW+2)'(dp_z_ff);
      full_c = (hs_ff >= lim_ff);
      take_c = !dot_sum[QW+1] && (dist_sum <= max_ff) && (!full_c || dist_sum < worst_ff);
   end

   always_comb begin
      hs_ext = {1'b0, hs_ff};
      l_c = {LW'(hi_ff), 1'b1};
      r_c = l_c + 1'b1;
      l_idx = l_c[HW-1:0];
      r_idx = r_c[HW-1:0];
      big_idx = l_idx;
      if (l_c >= hs_ext) begin
         sd_stop = 1'b1;
      end else if (r_c >= hs_ext) begin
         sd_stop = (cell_dist[hi_ff] >= cell_dist[l_idx]);
      end else begin
         sd_stop = (cell_dist[hi_ff] >= cell_dist[l_idx]) &&
                   (cell_dist[hi_ff] >= cell_dist[r_idx]);
         big_idx = (cell_dist[l_idx] > cell_dist[r_idx]) ? l_idx : r_idx;
      end
      p_idx = (hi_ff - 1'b1) >> 1;
      su_stop = (hi_ff == '0) || (cell_dist[p_idx] >= cell_dist[hi_ff]);
      last_idx = HW'(hs_ff - 1'b1);
   end

   always_comb begin
      wa_en = 1'b0;
      wb_en = 1'b0;
      shift_c = 1'b0;
      wa_idx = '0;
      wb_idx = '0;
      wa_slot = cons_slot_ff;
      wb_slot = cons_slot_ff;
      wa_dist = dist_sum;
      wb_dist = dist_sum;
      case (state_ff)
         S_CONS_SUM: begin
            if (take_c) begin
               wa_en = 1'b1;
               if (full_c) begin
                  wa_idx = '0;
                  wa_slot = cell_slot[last_idx];
                  wa_dist = cell_dist[last_idx];
               end else begin
                  wa_idx = hs_ff[HW-1:0];
               end
            end
         end
         S_SD: begin
            wa_en = 1'b1;
            if (sd_stop) begin
               wa_idx = hs_ff[HW-1:0];
               wa_slot = pend_slot_ff;
               wa_dist = pend_dist_ff;
            end else begin
               wb_en = 1'b1;
               wa_idx = hi_ff;
               wa_slot = cell_slot[big_idx];
               wa_dist = cell_dist[big_idx];
               wb_idx = big_idx;
               wb_slot = cell_slot[hi_ff];
               wb_dist = cell_dist[hi_ff];
            end
         end
         S_SU: begin
            if (!su_stop) begin
               wa_en = 1'b1;
               wb_en = 1'b1;
               wa_idx = hi_ff;
               wa_slot = cell_slot[p_idx];
               wa_dist = cell_dist[p_idx];
               wb_idx = p_idx;
               wb_slot = cell_slot[hi_ff];
               wb_dist = cell_dist[hi_ff];
            end
         end
         S_OUT: shift_c = (hs_ff != '0);
         default: ;
      endcase
   end

   for (genvar j = 0; j < KM; j++) begin : g_heap
      kdk_pkg::cell_ctl_type ctl;
      logic [SW-1:0] nb_slot, c_wslot;
      logic [DW-1:0] nb_dist, c_wdist;
      logic hit_a, hit_b;

      assign hit_a = wa_en && (wa_idx == HW'(j));
      assign hit_b = wb_en && (wb_idx == HW'(j));
      assign ctl.we = hit_a || hit_b;
      assign ctl.shift = shift_c;
      assign c_wslot = hit_a ? wa_slot : wb_slot;
      assign c_wdist = hit_a ? wa_dist : wb_dist;

      if (j < KM - 1) begin : g_mid
         assign nb_slot = cell_slot[j+1];
         assign nb_dist = cell_dist[j+1];
      end else begin : g_end
         assign nb_slot = '0;
         assign nb_dist = '0;
      end

      kdk_cell u_cell (
         .clock(clock),
         .ctl(ctl),
         .nb_slot(nb_slot),
         .nb_dist(nb_dist),
         .wr_slot(c_wslot),
         .wr_dist(c_wdist),
         .slot(cell_slot[j]),
         .dist_out(cell_dist[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         max_ff <= kdk_pkg::MAX_SQ_DIST_RESET;
         limit_ff <= LW'(KM);
         count_ff <= '0;
         hs_ff <= '0;
         worst_ff <= '0;
         sp_ff <= '0;
         lim_ff <= LW'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == S_OUT);
         if (csr_write_enable) begin
            unique case (csr_index)
               kdk_pkg::CSR_MAX_SQ_DIST:    max_ff <= csr_data;
               kdk_pkg::CSR_NEIGHBOR_LIMIT: limit_ff <= csr_data[LW-1:0];
               kdk_pkg::CSR_PHOTON_COUNT:   count_ff <= csr_data[NW-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept_req && req_op == kdk_pkg::OP_QUERY) begin
                  qx_ff <= req_coord_x;
                  qy_ff <= req_coord_y;
                  qz_ff <= req_coord_z;
                  nx_ff <= req_vec_x;
                  ny_ff <= req_vec_y;
                  nz_ff <= req_vec_z;
                  if (limit_ff == '0) begin
                     lim_ff <= LW'(1);
                  end else if (limit_ff > LW'(KM)) begin
                     lim_ff <= LW'(KM);
                  end else begin
                     lim_ff <= limit_ff;
                  end
                  cur_lo_ff <= '0;
                  cur_hi_ff <= (count_ff > NW'(kdk_pkg::N_PHOTONS)) ?
                               NW'(kdk_pkg::N_PHOTONS) : count_ff;
                  hs_ff <= '0;
                  worst_ff <= '0;
                  sp_ff <= '0;
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (cur_lo_ff >= cur_hi_ff) begin
                  state_ff <= S_RET;
               end else if (cur_hi_ff == cur_lo_ff + 1'b1) begin
                  cons_slot_ff <= cur_lo_ff[SW-1:0];
                  cont_after_ff <= 1'b0;
                  state_ff <= S_CONS_MUL;
               end else begin
                  state_ff <= S_NODE;
               end
            end
            S_NODE: begin
               stack_ff[sp_ff[SIDX_W_FIX-1:0]] <= '{lo: cur_lo_ff, hi: cur_hi_ff,
                                                    near_high: (ax_p > ax_s)};
               sp_ff <= sp_ff + 1'b1;
               if (ax_p > ax_s) begin
                  cur_lo_ff <= mid_c + 1'b1;
               end else begin
                  cur_hi_ff <= mid_c;
               end
               state_ff <= S_WALK;
            end
            S_RET: begin
               if (sp_ff == '0) begin
                  out_k_ff <= '0;
                  state_ff <= S_OUT;
               end else begin
                  cur_lo_ff <= top_c.lo;
                  cur_hi_ff <= top_c.hi;
                  cur_nh_ff <= top_c.near_high;
                  sp_ff <= sp_m1;
                  cons_slot_ff <= pop_mid_c[SW-1:0];
                  cont_after_ff <= 1'b1;
                  state_ff <= S_CONS_MUL;
               end
            end
            S_CONS_MUL: begin
               sq_x_ff <= sqx_full[QW-1:0];
               sq_y_ff <= sqy_full[QW-1:0];
               sq_z_ff <= sqz_full[QW-1:0];
               g2_ff <= g2_full[QW-1:0];
               dp_x_ff <= dpx_c;
               dp_y_ff <= dpy_c;
               dp_z_ff <= dpz_c;
               state_ff <= S_CONS_SUM;
            end
            S_CONS_SUM: begin
               if (!take_c) begin
                  state_ff <= cont_after_ff ? S_AFTER : S_RET;
               end else if (full_c) begin
                  hs_ff <= hs_ff - 1'b1;
                  pend_slot_ff <= cons_slot_ff;
                  pend_dist_ff <= dist_sum;
                  hi_ff <= '0;
                  state_ff <= S_SD;
               end else begin
                  hs_ff <= hs_ff + 1'b1;
                  hi_ff <= hs_ff[HW-1:0];
                  state_ff <= S_SU;
               end
            end
            S_SD: begin
               if (sd_stop) begin
                  hs_ff <= hs_ff + 1'b1;
                  hi_ff <= hs_ff[HW-1:0];
                  state_ff <= S_SU;
               end else begin
                  hi_ff <= big_idx;
               end
            end
            S_SU: begin
               if (su_stop) begin
                  worst_ff <= cell_dist[0];
                  state_ff <= cont_after_ff ? S_AFTER : S_RET;
               end else begin
                  hi_ff <= p_idx;
               end
            end
            S_AFTER: begin
               if (full_c && DW'(g2_ff) > worst_ff) begin
                  state_ff <= S_RET;
               end else begin
                  if (cur_nh_ff) begin
                     cur_hi_ff <= mid_c;
                  end else begin
                     cur_lo_ff <= mid_c + 1'b1;
                  end
                  state_ff <= S_WALK;
               end
            end
            S_OUT: begin
               if (hs_ff == '0) begin
                  rsp_valid_ff <= 1'b0;
                  rsp_slot_ff <= '0;
                  rsp_dist_ff <= '0;
                  rsp_count_ff <= '0;
                  rsp_worst_ff <= '0;
                  rsp_last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_slot_ff <= cell_slot[0];
                  rsp_dist_ff <= cell_dist[0];
                  rsp_count_ff <= hs_ff;
                  rsp_worst_ff <= worst_ff;
                  rsp_last_ff <= (out_k_ff + 1'b1 == hs_ff);
                  out_k_ff <= out_k_ff + 1'b1;
                  if (out_k_ff + 1'b1 == hs_ff) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_neighbor_slot = rsp_slot_ff;
   assign rsp_neighbor_sq_dist = rsp_dist_ff;
   assign rsp_valid_res = rsp_valid_ff;
   assign rsp_neighbor_count = rsp_count_ff;
   assign rsp_worst_sq_dist = rsp_worst_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTH
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= kdk_pkg::SP_W'(kdk_pkg::STACK_DEPTH))
      else $error("walk stack overflow");

   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> hs_ff <= lim_ff)
      else $error("heap holds more than the limit");

   a_root_worst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_valid_res) |-> rsp_neighbor_sq_dist <= rsp_worst_sq_dist)
      else $error("neighbour beyond heap root");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |-> rsp_last)
      else $error("empty result not final");
`endif

endmodule

### dv/kd_tree_k_nearest_search_tb.sv
module kd_tree_k_nearest_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [kdk_pkg::SLOT_W-1:0] slot;
      logic [kdk_pkg::DIST_W-1:0] sq_dist;
      logic valid;
      logic [kdk_pkg::LIM_W-1:0] count;
      logic [kdk_pkg::DIST_W-1:0] worst;
      logic last;
   } neighbor_result_type;

   class neighbor_scoreboard;
      int pos[kdk_pkg::N_PHOTONS][3];
      int dir[kdk_pkg::N_PHOTONS][3];
      logic [1:0] axis[kdk_pkg::N_PHOTONS];
      longint dist_limit;
      int keep_limit;
      int tree_size;
      int query_pt[3];
      int query_norm[3];
      int active_limit;
      int heap_slot[kdk_pkg::K_MAX];
      longint heap_dist[kdk_pkg::K_MAX];
      int heap_size;
      longint worst_kept;
      neighbor_result_type expected_results[$];
      int errors;

      function new();
         dist_limit = 64'd12884508675;
         keep_limit = 16;
         tree_size = 0;
         errors = 0;
      endfunction

      task report(string msg);
         $display("%0t: %s", $realtime, msg);
         errors++;
      endtask

      function void set_register(logic [kdk_pkg::CSR_IDX_W-1:0] idx,
                                 logic [kdk_pkg::DIST_W-1:0] value);
         case (idx)
            kdk_pkg::CSR_MAX_SQ_DIST: dist_limit = longint'(value);
            kdk_pkg::CSR_NEIGHBOR_LIMIT: keep_limit = int'(value[kdk_pkg::LIM_W-1:0]);
            kdk_pkg::CSR_PHOTON_COUNT: tree_size = int'(value[kdk_pkg::CNT_W-1:0]);
            default: ;
         endcase
      endfunction

      function void swap_entries(int a, int b);
         int ts;
         longint td;
         ts = heap_slot[a]; heap_slot[a] = heap_slot[b]; heap_slot[b] = ts;
         td = heap_dist[a]; heap_dist[a] = heap_dist[b]; heap_dist[b] = td;
      endfunction

      function void drop_root();
         int i, l, r, big;
         i = 0;
         if (heap_size == 0) return;
         heap_slot[0] = heap_slot[heap_size-1];
         heap_dist[0] = heap_dist[heap_size-1];
         heap_size--;
         forever begin
            l = 2*i + 1;
            r = 2*i + 2;
            if (l >= heap_size) return;
            if (r >= heap_size) begin
               if (heap_dist[i] >= heap_dist[l]) return;
               swap_entries(i, l);
               i = l;
            end else begin
               if (heap_dist[i] >= heap_dist[l] && heap_dist[i] >= heap_dist[r]) return;
               big = (heap_dist[l] > heap_dist[r]) ? l : r;
               swap_entries(i, big);
               i = big;
            end
         end
      endfunction

      function void push_entry(int slot, longint entry_dist);
         int i, p;
         i = heap_size;
         if (i >= kdk_pkg::K_MAX) return;
         heap_slot[i] = slot;
         heap_dist[i] = entry_dist;
         heap_size++;
         while (i > 0) begin
            p = (i - 1) / 2;
            if (heap_dist[p] >= heap_dist[i]) return;
            swap_entries(i, p);
            i = p;
         end
      endfunction

      function void consider_photon(int e);
         longint dot, sq_dist, d;
         dot = 0;
         sq_dist = 0;
         for (int k = 0; k < 3; k++) begin
            d = longint'(query_pt[k]) - longint'(pos[e][k]);
            dot += longint'(query_norm[k]) * longint'(dir[e][k]);
            sq_dist += d * d;
         end
         if (dot < 0) return;
         if (sq_dist <= dist_limit && (heap_size < active_limit || sq_dist < worst_kept)) begin
            if (heap_size >= active_limit) drop_root();
            push_entry(e, sq_dist);
            worst_kept = heap_dist[0];
         end
      endfunction

      function void walk_range(int lo, int hi);
         int m;
         longint s, p, g;
         if (lo >= hi) return;
         if (lo + 1 == hi) begin
            consider_photon(lo);
            return;
         end
         m = lo + (hi - lo) / 2;
         s = 0;
         p = 0;
         if (axis[m] != kdk_pkg::AXIS_LEAF) begin
            s = pos[m][axis[m] - 1];
            p = query_pt[axis[m] - 1];
         end
         g = p - s;
         if (p <= s) begin
            walk_range(lo, m);
            consider_photon(m);
            if (heap_size >= active_limit && g * g > worst_kept) return;
            walk_range(m + 1, hi);
         end else begin
            walk_range(m + 1, hi);
            consider_photon(m);
            if (heap_size >= active_limit && g * g > worst_kept) return;
            walk_range(lo, m);
         end
      endfunction

      function void note_request(logic op, int slot, int cx, int cy, int cz,
                                 int vx, int vy, int vz, logic [1:0] ax);
         neighbor_result_type r;
         int n;
         if (op == kdk_pkg::OP_LOAD) begin
            pos[slot][0] = cx; pos[slot][1] = cy; pos[slot][2] = cz;
            dir[slot][0] = vx; dir[slot][1] = vy; dir[slot][2] = vz;
            axis[slot] = ax;
            return;
         end
         query_pt[0] = cx; query_pt[1] = cy; query_pt[2] = cz;
         query_norm[0] = vx; query_norm[1] = vy; query_norm[2] = vz;
         active_limit = keep_limit < 1 ? 1 :
                        (keep_limit > kdk_pkg::K_MAX ? kdk_pkg::K_MAX : keep_limit);
         n = tree_size > kdk_pkg::N_PHOTONS ? kdk_pkg::N_PHOTONS : tree_size;
         heap_size = 0;
         worst_kept = 0;
         walk_range(0, n);
         if (heap_size == 0) begin
            r = '{slot: '0, sq_dist: '0, valid: 1'b0, count: '0, worst: '0, last: 1'b1};
            expected_results.insert(expected_results.size(), r);
            return;
         end
         for (int k = 0; k < heap_size; k++) begin
            r.slot = kdk_pkg::SLOT_W'(heap_slot[k]);
            r.sq_dist = kdk_pkg::DIST_W'(heap_dist[k]);
            r.valid = 1'b1;
            r.count = kdk_pkg::LIM_W'(heap_size);
            r.worst = kdk_pkg::DIST_W'(heap_dist[0]);
            r.last = (k + 1 == heap_size);
            expected_results.insert(expected_results.size(), r);
         end
      endfunction

      task check_result(neighbor_result_type got);
         neighbor_result_type exp;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected result slot %0d", got.slot));
            return;
         end
         exp = expected_results.pop_front();
         if (got.slot !== exp.slot)
            report($sformatf("neighbor_slot %0d, expected %0d", got.slot, exp.slot));
         if (got.sq_dist !== exp.sq_dist)
            report($sformatf("neighbor_sq_dist %0d, expected %0d", got.sq_dist, exp.sq_dist));
         if (got.valid !== exp.valid)
            report($sformatf("valid_res %0b, expected %0b", got.valid, exp.valid));
         if (got.count !== exp.count)
            report($sformatf("neighbor_count %0d, expected %0d", got.count, exp.count));
         if (got.worst !== exp.worst)
            report($sformatf("worst_sq_dist %0d, expected %0d", got.worst, exp.worst));
         if (got.last !== exp.last)
            report($sformatf("last %0b, expected %0b", got.last, exp.last));
      endtask
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_op;
   logic [kdk_pkg::SLOT_W-1:0] req_slot;
   logic signed [kdk_pkg::COORD_BITS-1:0] req_coord_x, req_coord_y, req_coord_z;
   logic signed [kdk_pkg::COORD_BITS-1:0] req_vec_x, req_vec_y, req_vec_z;
   logic [1:0] req_split_axis;
   logic rsp_strobe;
   logic [kdk_pkg::SLOT_W-1:0] rsp_neighbor_slot;
   logic [kdk_pkg::DIST_W-1:0] rsp_neighbor_sq_dist;
   logic rsp_valid_res;
   logic [kdk_pkg::LIM_W-1:0] rsp_neighbor_count;
   logic [kdk_pkg::DIST_W-1:0] rsp_worst_sq_dist;
   logic rsp_last;
   logic csr_write_enable;
   logic [kdk_pkg::CSR_IDX_W-1:0] csr_index;
   logic [kdk_pkg::DIST_W-1:0] csr_data;

   neighbor_scoreboard sb;
   int idle_pct;
   int small_coords;

   kd_tree_k_nearest_search uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result('{slot: rsp_neighbor_slot, sq_dist: rsp_neighbor_sq_dist,
                           valid: rsp_valid_res, count: rsp_neighbor_count,
                           worst: rsp_worst_sq_dist, last: rsp_last});
   end

   task automatic send_request(logic op, int slot, int cx, int cy, int cz,
                               int vx, int vy, int vz, logic [1:0] ax);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_op = op;
      req_slot = kdk_pkg::SLOT_W'(slot);
      req_coord_x = kdk_pkg::COORD_BITS'(cx);
      req_coord_y = kdk_pkg::COORD_BITS'(cy);
      req_coord_z = kdk_pkg::COORD_BITS'(cz);
      req_vec_x = kdk_pkg::COORD_BITS'(vx);
      req_vec_y = kdk_pkg::COORD_BITS'(vy);
      req_vec_z = kdk_pkg::COORD_BITS'(vz);
      req_split_axis = ax;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_request(op, int'(req_slot), int'(req_coord_x), int'(req_coord_y),
                      int'(req_coord_z), int'(req_vec_x), int'(req_vec_y),
                      int'(req_vec_z), ax);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      start = 1'b0;
      while (sb.expected_results.size() > 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(logic [kdk_pkg::CSR_IDX_W-1:0] idx, longint value);
      @(negedge clock);
      start = 1'b0;
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_data = kdk_pkg::DIST_W'(value);
      sb.set_register(idx, csr_data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic int pick_coord();
      if (small_coords) return $urandom_range(200) - 100;
      return $signed(16'($urandom));
   endfunction

   task automatic load_photon(int slot);
      send_request(kdk_pkg::OP_LOAD, slot, pick_coord(), pick_coord(), pick_coord(),
                   pick_coord(), pick_coord(), pick_coord(), 2'($urandom));
   endtask

   task automatic run_query();
      int vx, vy, vz;
      vx = pick_coord(); vy = pick_coord(); vz = pick_coord();
      if ($urandom_range(5) == 0) begin
         vx = 0; vy = 0; vz = 0;
      end
      send_request(kdk_pkg::OP_QUERY, int'($urandom_range(kdk_pkg::N_PHOTONS - 1)),
                   pick_coord(), pick_coord(), pick_coord(), vx, vy, vz, 2'($urandom));
   endtask

   initial begin
      int n, random_items;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_op = kdk_pkg::OP_LOAD;
      req_slot = '0;
      req_coord_x = '0; req_coord_y = '0; req_coord_z = '0;
      req_vec_x = '0; req_vec_y = '0; req_vec_z = '0;
      req_split_axis = kdk_pkg::AXIS_LEAF;
      csr_write_enable = 1'b0;
      csr_index = kdk_pkg::CSR_MAX_SQ_DIST;
      csr_data = '0;
      idle_pct = 20;
      small_coords = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: an empty tree, extreme values, facing-away photons and leaf flags.
      send_request(kdk_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, kdk_pkg::AXIS_LEAF);
      send_request(kdk_pkg::OP_LOAD, 0, -32768, -32768, -32768, 32767, 32767, 32767,
                   kdk_pkg::AXIS_X);
      send_request(kdk_pkg::OP_LOAD, 1, 32767, 32767, 32767, -32768, -32768, -32768,
                   kdk_pkg::AXIS_Y);
      send_request(kdk_pkg::OP_LOAD, 2, 0, 0, 0, 1, 0, 0, kdk_pkg::AXIS_LEAF);
      send_request(kdk_pkg::OP_LOAD, 3, 5, -5, 5, 0, 0, 0, kdk_pkg::AXIS_Z);
      send_request(kdk_pkg::OP_LOAD, 4, 5, -5, 5, 0, 1, 0, kdk_pkg::AXIS_LEAF);
      send_request(kdk_pkg::OP_LOAD, 5, -1, 1, -1, 0, 0, -1, kdk_pkg::AXIS_X);
      send_request(kdk_pkg::OP_LOAD, 6, 100, 100, 100, 7, 7, 7, kdk_pkg::AXIS_Y);
      send_request(kdk_pkg::OP_LOAD, 7, 32767, -32768, 0, 3, -3, 0, kdk_pkg::AXIS_Z);
      wait_quiet();
      write_register(kdk_pkg::CSR_PHOTON_COUNT, 8);
      send_request(kdk_pkg::OP_QUERY, 0, 32767, 32767, 32767, 0, 0, 0, kdk_pkg::AXIS_LEAF);
      send_request(kdk_pkg::OP_QUERY, 0, -32768, -32768, -32768, 1, 1, 1, kdk_pkg::AXIS_LEAF);
      send_request(kdk_pkg::OP_QUERY, 0, 5, -5, 5, -1, -1, -1, kdk_pkg::AXIS_LEAF);
      wait_quiet();
      write_register(kdk_pkg::CSR_NEIGHBOR_LIMIT, 0);
      write_register(kdk_pkg::CSR_MAX_SQ_DIST, 0);
      send_request(kdk_pkg::OP_QUERY, 0, 5, -5, 5, 0, 0, 0, kdk_pkg::AXIS_LEAF);
      send_request(kdk_pkg::OP_QUERY, 0, 1, 2, 3, 0, 0, 0, kdk_pkg::AXIS_LEAF);
      wait_quiet();
      write_register(kdk_pkg::CSR_NEIGHBOR_LIMIT, 31);
      write_register(kdk_pkg::CSR_MAX_SQ_DIST, 64'd12884508675);
      send_request(kdk_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, kdk_pkg::AXIS_LEAF);
      send_request(kdk_pkg::OP_QUERY, 0, 32767, -32768, 0, 32767, -32768, 1,
                   kdk_pkg::AXIS_LEAF);
      wait_quiet();
      write_register(kdk_pkg::CSR_NEIGHBOR_LIMIT, 3);
      send_request(kdk_pkg::OP_QUERY, 0, -1, 1, -1, 0, 0, 0, kdk_pkg::AXIS_LEAF);
      wait_quiet();

      random_items = 0;
      while (random_items < 180) begin
         idle_pct = (random_items < 60) ? 20 : (random_items < 120) ? 81 : 0;
         small_coords = ($urandom_range(3) != 0);
         n = ($urandom_range(7) == 0) ? $urandom_range(24, 48) : $urandom_range(1, 16);
         for (int s = 0; s < n; s++) load_photon(s);
         random_items += n;
         wait_quiet();
         write_register(kdk_pkg::CSR_PHOTON_COUNT, ($urandom_range(9) == 0) ? 0 : n);
         write_register(kdk_pkg::CSR_NEIGHBOR_LIMIT, $urandom_range(31));
         case ($urandom_range(3))
            0: write_register(kdk_pkg::CSR_MAX_SQ_DIST, 64'd12884508675);
            1: write_register(kdk_pkg::CSR_MAX_SQ_DIST, $urandom_range(30000));
            2: write_register(kdk_pkg::CSR_MAX_SQ_DIST,
                              {$urandom, $urandom} & 34'h3FFFFFFFF);
            default: write_register(kdk_pkg::CSR_MAX_SQ_DIST, 0);
         endcase
         repeat ($urandom_range(3, 8)) begin
            if ($urandom_range(4) == 0) load_photon($urandom_range(n - 1));
            else run_query();
            random_items++;
         end
         wait_quiet();
      end

      wait_quiet();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

### sim.f
sv/kdk_pkg.sv
sv/kdk_ram.sv
sv/kdk_cell.sv
sv/kd_tree_k_nearest_search.sv
dv/kd_tree_k_nearest_search_tb.sv
